// File: sv/wphe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wphe_pkg
// shared types and constants of the window pointer hit engine
// ----------------------------------------------------------------------------
package wphe_pkg;

    localparam logic [2:0] CMD_MOVE_X  = 3'd0;
    localparam logic [2:0] CMD_MOVE_Y  = 3'd1;
    localparam logic [2:0] CMD_PRESS   = 3'd2;
    localparam logic [2:0] CMD_RELEASE = 3'd3;
    localparam logic [2:0] CMD_CREATE  = 3'd4;
    localparam logic [2:0] CMD_DESTROY = 3'd5;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [12:0] SCREEN_W_RST = 13'd1024;
    localparam logic [12:0] SCREEN_H_RST = 13'd768;
    localparam logic [11:0] PTR_X_RST    = 12'd512;
    localparam logic [11:0] PTR_Y_RST    = 12'd384;
    localparam logic [12:0] SCREEN_MAX   = 13'd4096;

    localparam int TITLE_H      = 28;
    localparam int BTN_SZ       = 16;
    localparam int BTN_MARG     = 6;
    localparam int BTN_OFF      = (TITLE_H - BTN_SZ) / 2;
    localparam int CASCADE_BASE = 50;
    localparam int CASCADE_STEP = 30;

    typedef struct packed {
        logic [31:0] id;
        logic [11:0] width;
    } attr_t;

    typedef struct packed {
        logic signed [13:0] left;
        logic signed [13:0] top;
    } pos_t;

endpackage

// File: sv/wphe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wphe_ram
// simple dual port memory, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module wphe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/window_pointer_hit_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_pointer_hit_engine_unit
// window table with cursor, focus and drag handling for pointer events
// ----------------------------------------------------------------------------
// one request at a time; N is the number of windows held
// move, release, create, unused codes: result, preceded by a position write on a drag move
// press: a scan of the N windows from the top, then compaction after a close hit
// destroy: a scan of the N windows, then compaction when the id is found
// the scan and the compaction stream one table entry a cycle through the memory read port
// reset clears control state at once; the table memories are not cleared
// ----------------------------------------------------------------------------
module window_pointer_hit_engine_unit #(
    parameter int MAX_WINDOW_SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // command[2:0], delta[18:3], win_id[50:19], win_width[62:51], zero[63]
    input  logic [63:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // ptr_col[11:0], ptr_row[23:12], focus_index[30:24], window_count[37:31],
    // drag_active[38], redraw[39], status[41:40], closed_id[73:42], zero[79:74]
    output logic [79:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [12:0] cfg_wdata
);

    localparam int IW = (MAX_WINDOW_SLOTS > 1) ? $clog2(MAX_WINDOW_SLOTS) : 1;
    localparam int CW = $clog2(MAX_WINDOW_SLOTS + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MOVE_WR = 3'd1;
    localparam logic [2:0] ST_HIT     = 3'd2;
    localparam logic [2:0] ST_DST     = 3'd3;
    localparam logic [2:0] ST_SHIFT   = 3'd4;
    localparam logic [2:0] ST_FIN     = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [12:0]        scr_w_reg, scr_w_next;
    logic [12:0]        scr_h_reg, scr_h_next;
    logic [11:0]        ptr_x_reg, ptr_x_next;
    logic [11:0]        ptr_y_reg, ptr_y_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               focus_vld_reg, focus_vld_next;
    logic [IW-1:0]      focus_idx_reg, focus_idx_next;
    logic               drag_reg, drag_next;
    logic [IW-1:0]      drag_idx_reg, drag_idx_next;
    logic signed [13:0] grab_x_reg, grab_x_next;
    logic signed [13:0] grab_y_reg, grab_y_next;
    logic [IW-1:0]      issue_idx_reg, issue_idx_next;
    logic               issue_more_reg, issue_more_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IW-1:0]      rd_idx_reg, rd_idx_next;
    logic               t_found_reg, t_found_next;
    logic [IW-1:0]      t_idx_reg, t_idx_next;
    logic signed [13:0] t_left_reg, t_left_next;
    logic signed [13:0] t_top_reg, t_top_next;
    logic [IW-1:0]      rm_idx_reg, rm_idx_next;
    logic [31:0]        key_id_reg, key_id_next;
    logic               res_redraw_reg, res_redraw_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [31:0]        res_closed_reg, res_closed_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [79:0]        m_tdata_reg, m_tdata_next;

    logic               accept;
    logic [2:0]         in_cmd;
    logic signed [15:0] in_delta;
    logic [31:0]        in_id;
    logic [11:0]        in_width;

    logic               attr_we;
    logic               pos_we;
    logic [IW-1:0]      wr_addr;
    wphe_pkg::attr_t    wr_attr;
    wphe_pkg::pos_t     wr_pos;
    wphe_pkg::attr_t    rd_attr;
    wphe_pkg::pos_t     rd_pos;

    logic [IW-1:0]      cnt_m1;
    logic [CW:0]        rd_idx_p1;
    logic [CW-1:0]      new_cnt;
    logic [CW-1:0]      new_cnt_m1;
    logic [IW+6:0]      focus_ext;
    logic [CW+6:0]      count_ext;
    logic [6:0]         focus_out;
    logic [15:0]        casc_full;
    logic [11:0]        clamp_x;
    logic [11:0]        clamp_y;

    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] ent_l;
    logic signed [15:0] ent_t;
    logic signed [15:0] ent_w;
    logic signed [15:0] cbx;
    logic signed [15:0] cby;
    logic               close_hit;
    logic               title_hit;

    function automatic logic [11:0] clamp_axis(
        input logic [11:0]        cur,
        input logic signed [15:0] d,
        input logic [12:0]        size
    );
        logic [12:0]        sz;
        logic signed [17:0] n;
        logic signed [17:0] lim;
        logic [11:0]        res;
        sz = size;
        if (sz == 13'd0)
        begin
            sz = 13'd1;
        end
        if (sz > wphe_pkg::SCREEN_MAX)
        begin
            sz = wphe_pkg::SCREEN_MAX;
        end
        lim = $signed({5'b0, sz}) - 18'sd1;
        n   = $signed({6'b0, cur}) + 18'(d);
        if (n < 18'sd0)
        begin
            res = 12'd0;
        end
        else if (n > lim)
        begin
            res = lim[11:0];
        end
        else
        begin
            res = n[11:0];
        end
        return res;
    endfunction

    assign in_cmd   = s_tdata[2:0];
    assign in_delta = $signed(s_tdata[18:3]);
    assign in_id    = s_tdata[50:19];
    assign in_width = s_tdata[62:51];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign cnt_m1     = IW'(count_reg - CW'(1));
    assign rd_idx_p1  = (CW+1)'(rd_idx_reg) + (CW+1)'(1);
    assign new_cnt    = count_reg - CW'(1);
    assign new_cnt_m1 = new_cnt - CW'(1);
    assign focus_ext  = {7'b0, focus_idx_reg};
    assign count_ext  = {7'b0, count_reg};
    assign focus_out  = focus_vld_reg ? focus_ext[6:0] : 7'h7F;
    assign casc_full  = 16'(wphe_pkg::CASCADE_BASE) +
                        16'(count_reg) * 16'(wphe_pkg::CASCADE_STEP);
    assign clamp_x    = clamp_axis(ptr_x_reg, in_delta, scr_w_reg);
    assign clamp_y    = clamp_axis(ptr_y_reg, in_delta, scr_h_reg);

    // hit tests on the entry coming out of the memories
    assign mx    = $signed({4'b0, ptr_x_reg});
    assign my    = $signed({4'b0, ptr_y_reg});
    assign ent_l = 16'(rd_pos.left);
    assign ent_t = 16'(rd_pos.top);
    assign ent_w = $signed({4'b0, rd_attr.width});
    assign cbx   = ent_l + ent_w - 16'(wphe_pkg::BTN_MARG + wphe_pkg::BTN_SZ);
    assign cby   = ent_t + 16'(wphe_pkg::BTN_OFF);

    assign close_hit = (mx >= cbx) && (mx <= cbx + 16'(wphe_pkg::BTN_SZ)) &&
                       (my >= cby) && (my <= cby + 16'(wphe_pkg::BTN_SZ));
    assign title_hit = (mx >= ent_l) && (mx < ent_l + ent_w) &&
                       (my >= ent_t) && (my < ent_t + 16'(wphe_pkg::TITLE_H));

    wphe_ram #(
        .WIDTH ($bits(wphe_pkg::attr_t)),
        .DEPTH (MAX_WINDOW_SLOTS)
    ) u_attr_ram (
        .clk   (clk),
        .we    (attr_we),
        .waddr (wr_addr),
        .wdata (wr_attr),
        .raddr (issue_idx_reg),
        .rdata (rd_attr)
    );

    wphe_ram #(
        .WIDTH ($bits(wphe_pkg::pos_t)),
        .DEPTH (MAX_WINDOW_SLOTS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (wr_addr),
        .wdata (wr_pos),
        .raddr (issue_idx_reg),
        .rdata (rd_pos)
    );

    always_comb
    begin
        state_next      = state_reg;
        scr_w_next      = scr_w_reg;
        scr_h_next      = scr_h_reg;
        ptr_x_next      = ptr_x_reg;
        ptr_y_next      = ptr_y_reg;
        count_next      = count_reg;
        focus_vld_next  = focus_vld_reg;
        focus_idx_next  = focus_idx_reg;
        drag_next       = drag_reg;
        drag_idx_next   = drag_idx_reg;
        grab_x_next     = grab_x_reg;
        grab_y_next     = grab_y_reg;
        issue_idx_next  = issue_idx_reg;
        issue_more_next = issue_more_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        t_found_next    = t_found_reg;
        t_idx_next      = t_idx_reg;
        t_left_next     = t_left_reg;
        t_top_next      = t_top_reg;
        rm_idx_next     = rm_idx_reg;
        key_id_next     = key_id_reg;
        res_redraw_next = res_redraw_reg;
        res_status_next = res_status_reg;
        res_closed_next = res_closed_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        attr_we         = 1'b0;
        pos_we          = 1'b0;
        wr_addr         = rd_idx_reg - IW'(1);
        wr_attr         = rd_attr;
        wr_pos          = rd_pos;

        if (cfg_we)
        begin
            unique case (cfg_addr)
                wphe_pkg::REG_SCREEN_WIDTH:  scr_w_next = cfg_wdata;
                wphe_pkg::REG_SCREEN_HEIGHT: scr_h_next = cfg_wdata;
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_redraw_next = 1'b0;
                    res_status_next = wphe_pkg::STAT_DONE;
                    res_closed_next = 32'd0;
                    t_found_next    = 1'b0;
                    key_id_next     = in_id;
                    state_next      = ST_FIN;
                    unique case (in_cmd)
                        wphe_pkg::CMD_MOVE_X, wphe_pkg::CMD_MOVE_Y:
                        begin
                            if (in_cmd == wphe_pkg::CMD_MOVE_X)
                            begin
                                ptr_x_next = clamp_x;
                            end
                            else
                            begin
                                ptr_y_next = clamp_y;
                            end
                            res_redraw_next = 1'b1;
                            if (drag_reg && (CW'(drag_idx_reg) < count_reg))
                            begin
                                state_next = ST_MOVE_WR;
                            end
                        end
                        wphe_pkg::CMD_PRESS:
                        begin
                            issue_idx_next  = cnt_m1;
                            issue_more_next = (count_reg != CW'(0));
                            state_next      = ST_HIT;
                        end
                        wphe_pkg::CMD_RELEASE:
                        begin
                            drag_next = 1'b0;
                        end
                        wphe_pkg::CMD_CREATE:
                        begin
                            if (count_reg >= CW'(MAX_WINDOW_SLOTS))
                            begin
                                res_status_next = wphe_pkg::STAT_FULL;
                            end
                            else
                            begin
                                attr_we         = 1'b1;
                                pos_we          = 1'b1;
                                wr_addr         = count_reg[IW-1:0];
                                wr_attr.id      = in_id;
                                wr_attr.width   = in_width;
                                wr_pos.left     = casc_full[13:0];
                                wr_pos.top      = casc_full[13:0];
                                focus_vld_next  = 1'b1;
                                focus_idx_next  = count_reg[IW-1:0];
                                count_next      = count_reg + CW'(1);
                                res_redraw_next = 1'b1;
                            end
                        end
                        wphe_pkg::CMD_DESTROY:
                        begin
                            issue_idx_next  = IW'(0);
                            issue_more_next = (count_reg != CW'(0));
                            state_next      = ST_DST;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_MOVE_WR:
            begin
                pos_we      = 1'b1;
                wr_addr     = drag_idx_reg;
                wr_pos.left = $signed({2'b00, ptr_x_reg}) - grab_x_reg;
                wr_pos.top  = $signed({2'b00, ptr_y_reg}) - grab_y_reg;
                state_next  = ST_FIN;
            end

            ST_HIT:
            begin
                // top entry first
                if (issue_more_reg)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_idx_reg;
                    if (issue_idx_reg == IW'(0))
                    begin
                        issue_more_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg - IW'(1);
                    end
                end
                if (rd_vld_reg && close_hit)
                begin
                    res_closed_next = rd_attr.id;
                    rm_idx_next     = rd_idx_reg;
                    rd_vld_next     = 1'b0;
                    issue_idx_next  = rd_idx_p1[IW-1:0];
                    issue_more_next = (rd_idx_p1 < (CW+1)'(count_reg));
                    state_next      = ST_SHIFT;
                end
                else
                begin
                    if (rd_vld_reg && title_hit && !t_found_reg)
                    begin
                        t_found_next = 1'b1;
                        t_idx_next   = rd_idx_reg;
                        t_left_next  = rd_pos.left;
                        t_top_next   = rd_pos.top;
                    end
                    if (!issue_more_reg && !rd_vld_reg)
                    begin
                        if (t_found_reg)
                        begin
                            focus_vld_next  = 1'b1;
                            focus_idx_next  = t_idx_reg;
                            drag_next       = 1'b1;
                            drag_idx_next   = t_idx_reg;
                            grab_x_next     = $signed({2'b00, ptr_x_reg}) - t_left_reg;
                            grab_y_next     = $signed({2'b00, ptr_y_reg}) - t_top_reg;
                            res_redraw_next = 1'b1;
                        end
                        state_next = ST_FIN;
                    end
                end
            end

            ST_DST:
            begin
                // lowest entry first
                if (issue_more_reg)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_idx_reg;
                    if (issue_idx_reg == cnt_m1)
                    begin
                        issue_more_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + IW'(1);
                    end
                end
                if (rd_vld_reg && (rd_attr.id == key_id_reg))
                begin
                    rm_idx_next     = rd_idx_reg;
                    rd_vld_next     = 1'b0;
                    issue_idx_next  = rd_idx_p1[IW-1:0];
                    issue_more_next = (rd_idx_p1 < (CW+1)'(count_reg));
                    state_next      = ST_SHIFT;
                end
                else if (!issue_more_reg && !rd_vld_reg)
                begin
                    res_status_next = wphe_pkg::STAT_NOT_FOUND;
                    state_next      = ST_FIN;
                end
            end

            ST_SHIFT:
            begin
                // read entry j, write it back at j - 1
                if (issue_more_reg)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_idx_reg;
                    if (issue_idx_reg == cnt_m1)
                    begin
                        issue_more_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + IW'(1);
                    end
                end
                if (rd_vld_reg)
                begin
                    attr_we = 1'b1;
                    pos_we  = 1'b1;
                end
                if (!issue_more_reg && !rd_vld_reg)
                begin
                    count_next = new_cnt;
                    if (focus_vld_reg && (CW'(focus_idx_reg) >= new_cnt))
                    begin
                        if (new_cnt == CW'(0))
                        begin
                            focus_vld_next = 1'b0;
                        end
                        else
                        begin
                            focus_idx_next = new_cnt_m1[IW-1:0];
                        end
                    end
                    if (drag_reg && (drag_idx_reg == rm_idx_reg))
                    begin
                        drag_next = 1'b0;
                    end
                    else if (drag_reg && (drag_idx_reg > rm_idx_reg))
                    begin
                        drag_idx_next = drag_idx_reg - IW'(1);
                    end
                    res_redraw_next = 1'b1;
                    state_next      = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, res_closed_reg, res_status_reg, res_redraw_reg,
                                     drag_reg, count_ext[6:0], focus_out, ptr_y_reg,
                                     ptr_x_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scr_w_reg      <= wphe_pkg::SCREEN_W_RST;
            scr_h_reg      <= wphe_pkg::SCREEN_H_RST;
            ptr_x_reg      <= wphe_pkg::PTR_X_RST;
            ptr_y_reg      <= wphe_pkg::PTR_Y_RST;
            count_reg      <= '0;
            focus_vld_reg  <= 1'b0;
            focus_idx_reg  <= '0;
            drag_reg       <= 1'b0;
            drag_idx_reg   <= '0;
            grab_x_reg     <= '0;
            grab_y_reg     <= '0;
            issue_more_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            t_found_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scr_w_reg      <= scr_w_next;
            scr_h_reg      <= scr_h_next;
            ptr_x_reg      <= ptr_x_next;
            ptr_y_reg      <= ptr_y_next;
            count_reg      <= count_next;
            focus_vld_reg  <= focus_vld_next;
            focus_idx_reg  <= focus_idx_next;
            drag_reg       <= drag_next;
            drag_idx_reg   <= drag_idx_next;
            grab_x_reg     <= grab_x_next;
            grab_y_reg     <= grab_y_next;
            issue_more_reg <= issue_more_next;
            rd_vld_reg     <= rd_vld_next;
            t_found_reg    <= t_found_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg  <= issue_idx_next;
        rd_idx_reg     <= rd_idx_next;
        t_idx_reg      <= t_idx_next;
        t_left_reg     <= t_left_next;
        t_top_reg      <= t_top_next;
        rm_idx_reg     <= rm_idx_next;
        key_id_reg     <= key_id_next;
        res_redraw_reg <= res_redraw_next;
        res_status_reg <= res_status_next;
        res_closed_reg <= res_closed_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule
